/* rtl/core/signed_floor_div_by_reciprocal_top_macros.svh */
// Assertion macros shared by the divider RTL.
`ifndef SIGNED_FLOOR_DIV_BY_RECIPROCAL_TOP_MACROS_SVH
`define SIGNED_FLOOR_DIV_BY_RECIPROCAL_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Consequent must hold in the same cycle as the antecedent.
`define SFDR_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfdr: same-cycle check failed");
// Consequent must hold in the cycle after the antecedent.
`define SFDR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfdr: next-cycle check failed");
`else
`define SFDR_ASSERT_SAME(label, clk, rst, ante, cons)
`define SFDR_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

/* rtl/core/sfdr_pkg.sv */
// Types and constants of the signed floor divider.
package sfdr_pkg;

   localparam int LIMB_W     = 32;
   localparam int DIVIDEND_W = 64;
   localparam int SHIFT_W    = 5;
   localparam int CSR_IDX_W  = 2;

   localparam logic [LIMB_W-1:0]  RESET_DIVISOR_NORM = 32'ha8c00000;
   localparam logic [LIMB_W-1:0]  RESET_RECIPROCAL   = 32'h845c8a0c;
   localparam logic [SHIFT_W-1:0] RESET_NORM_SHIFT   = 5'd15;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DIVISOR_NORM = 2'd0,
      CSR_RECIPROCAL   = 2'd1,
      CSR_NORM_SHIFT   = 2'd2
   } csr_index_type;

   // Data that rides along with an item through a reciprocal step.
   typedef struct packed {
      logic              fold;     // dividend was negative
      logic [LIMB_W-1:0] lo_limb;  // low limb, consumed by the second step
      logic [LIMB_W-1:0] q_hi;     // upper quotient word from the first step
   } side_type;

endpackage

/* rtl/core/sfdr_req_if.sv */
// Request channel: carries the dividend.
interface sfdr_req_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [sfdr_pkg::DIVIDEND_W-1:0] dividend;

   modport source (output valid, output dividend, input ready);
   modport sink   (input valid, input dividend, output ready);
endinterface

/* rtl/core/sfdr_rsp_if.sv */
// Response channel: carries quotient and remainder.
interface sfdr_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic signed [sfdr_pkg::DIVIDEND_W-1:0] quotient;
   logic        [sfdr_pkg::LIMB_W-1:0]     remainder;

   modport source (output valid, output quotient, output remainder, input ready);
   modport sink   (input valid, input quotient, input remainder, output ready);
endinterface

/* rtl/core/sfdr_step.sv */
// One pipelined reciprocal division step of a limb pair, four register stages.
`include "signed_floor_div_by_reciprocal_top_macros.svh"

module sfdr_step (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         in_valid,
   input  logic [sfdr_pkg::LIMB_W-1:0]  in_hi,
   input  logic [sfdr_pkg::LIMB_W-1:0]  in_lo,
   input  sfdr_pkg::side_type           in_side,
   input  logic [sfdr_pkg::LIMB_W-1:0]  divisor,
   input  logic [sfdr_pkg::LIMB_W-1:0]  recip,
   output logic                         out_valid,
   output logic [sfdr_pkg::LIMB_W-1:0]  out_quot,
   output logic [sfdr_pkg::LIMB_W-1:0]  out_rem,
   output sfdr_pkg::side_type           out_side
);

   localparam int W = sfdr_pkg::LIMB_W;

   // stage 1: hi * recip + lo
   logic               s1_valid_ff;
   logic [2*W-1:0]     s1_acc_ff, s1_acc_in;
   logic [W-1:0]       s1_hi_ff, s1_lo_ff;
   sfdr_pkg::side_type s1_side_ff;
   // stage 2: quotient estimate
   logic               s2_valid_ff;
   logic [W-1:0]       s2_qhi_ff, s2_qhi_in, s2_qlo_ff, s2_lo_ff;
   sfdr_pkg::side_type s2_side_ff;
   // stage 3: remainder estimate
   logic               s3_valid_ff;
   logic [W-1:0]       s3_qhi_ff, s3_qlo_ff, s3_rem_ff, s3_rem_in;
   sfdr_pkg::side_type s3_side_ff;
   // stage 4: corrected result
   logic               s4_valid_ff;
   logic [W-1:0]       s4_quot_ff, s4_quot_in, s4_rem_ff, s4_rem_in;
   sfdr_pkg::side_type s4_side_ff;

   logic [W-1:0]       fix_quot, fix_rem;

   always_comb begin
      s1_acc_in = (2*W)'(in_hi) * (2*W)'(recip) + (2*W)'(in_lo);
      s2_qhi_in = s1_acc_ff[2*W-1:W] + s1_hi_ff + W'(1);
      s3_rem_in = s2_lo_ff - s2_qhi_ff * divisor;

      // first correction: estimate one too high
      fix_quot = s3_qhi_ff;
      fix_rem  = s3_rem_ff;
      if (s3_rem_ff > s3_qlo_ff) begin
         fix_quot = s3_qhi_ff - W'(1);
         fix_rem  = s3_rem_ff + divisor;
      end
      // second correction: remainder still not below the divisor
      s4_quot_in = fix_quot;
      s4_rem_in  = fix_rem;
      if (fix_rem >= divisor) begin
         s4_quot_in = fix_quot + W'(1);
         s4_rem_in  = fix_rem - divisor;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (en) begin
         s1_valid_ff <= in_valid;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_acc_ff  <= s1_acc_in;
         s1_hi_ff   <= in_hi;
         s1_lo_ff   <= in_lo;
         s1_side_ff <= in_side;

         s2_qhi_ff  <= s2_qhi_in;
         s2_qlo_ff  <= s1_acc_ff[W-1:0];
         s2_lo_ff   <= s1_lo_ff;
         s2_side_ff <= s1_side_ff;

         s3_qhi_ff  <= s2_qhi_ff;
         s3_qlo_ff  <= s2_qlo_ff;
         s3_rem_ff  <= s3_rem_in;
         s3_side_ff <= s2_side_ff;

         s4_quot_ff <= s4_quot_in;
         s4_rem_ff  <= s4_rem_in;
         s4_side_ff <= s3_side_ff;
      end
   end

   assign out_valid = s4_valid_ff;
   assign out_quot  = s4_quot_ff;
   assign out_rem   = s4_rem_ff;
   assign out_side  = s4_side_ff;

   `SFDR_ASSERT_NEXT(a_step_holds_on_stall, clock, reset, !en,
      $stable({s1_valid_ff, s2_valid_ff, s3_valid_ff, s4_valid_ff}))
   `SFDR_ASSERT_NEXT(a_step_takes_item, clock, reset, en && in_valid, s1_valid_ff)

endmodule

/* rtl/core/signed_floor_div_by_reciprocal_top.sv */
// Top level of the signed floor divider by a precomputed reciprocal.
//
// Divides a signed 64-bit dividend by a 32-bit divisor and returns the floor
// quotient and a non-negative remainder. The divisor is programmed as three
// registers: divisor_norm (divisor shifted left until bit 31 is set),
// reciprocal (floor((2^64-1)/divisor_norm) - 2^32) and norm_shift; after
// reset they divide by 86400. Nothing checks that the three agree; a bad set
// simply gives wrong numbers. Write them only while no transfer is in flight.
// The pipeline takes one dividend per cycle and delivers one result per cycle
// while the response side keeps ready high. From the request transfer to a
// valid response, one stage folds and shifts the dividend
// into three limbs, each of the two chained reciprocal steps takes four stages
// (a 32x32 multiply by the reciprocal, the quotient estimate, a 32x32 multiply
// by the divisor, then the two corrections), and one stage unfolds the
// quotient and shifts the remainder back down. When the response is held off
// the whole pipeline freezes; req_chan.ready drops in the same cycle.
`include "signed_floor_div_by_reciprocal_top_macros.svh"

module signed_floor_div_by_reciprocal_top (
   input  logic                             clock,
   input  logic                             reset,
   sfdr_req_if.sink                         req_chan,
   sfdr_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [sfdr_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [sfdr_pkg::LIMB_W-1:0]      csr_wdata
);

   localparam int W = sfdr_pkg::LIMB_W;

   // configuration registers
   logic [W-1:0]                 divisor_norm_ff;
   logic [W-1:0]                 reciprocal_ff;
   logic [sfdr_pkg::SHIFT_W-1:0] norm_shift_ff;

   // pipeline advance: everything moves unless a finished result is stuck
   logic en;

   // fold stage
   logic                 a_valid_ff;
   logic [W-1:0]         a_hi_ff, a_hi_in, a_mid_ff, a_mid_in;
   sfdr_pkg::side_type   a_side_ff, a_side_in;
   logic [3*W-1:0]       shifted;
   logic [W-1:0]         fold_mask;

   // step outputs
   logic                 s1_valid, s2_valid;
   logic [W-1:0]         s1_quot, s1_rem, s2_quot, s2_rem;
   sfdr_pkg::side_type   s1_side, s2_side, s2_side_in;

   // output stage
   logic                                   o_valid_ff;
   logic signed [sfdr_pkg::DIVIDEND_W-1:0] o_quot_ff, o_quot_in;
   logic [W-1:0]                           o_rem_ff, o_rem_in, rem_sum;

   // Take configuration writes; drop writes to an unused index.
   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_norm_ff <= sfdr_pkg::RESET_DIVISOR_NORM;
         reciprocal_ff   <= sfdr_pkg::RESET_RECIPROCAL;
         norm_shift_ff   <= sfdr_pkg::RESET_NORM_SHIFT;
      end else if (csr_we) begin
         unique case (csr_index)
            sfdr_pkg::CSR_DIVISOR_NORM: begin
               divisor_norm_ff <= csr_wdata;
            end
            sfdr_pkg::CSR_RECIPROCAL: begin
               reciprocal_ff <= csr_wdata;
            end
            sfdr_pkg::CSR_NORM_SHIFT: begin
               norm_shift_ff <= csr_wdata[sfdr_pkg::SHIFT_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign en             = !o_valid_ff || rsp_chan.ready;
   assign req_chan.ready = en;

   // Fold a negative dividend by one's complement and cut the normalized
   // value into three limbs. With a zero shift the top limb stays zero.
   always_comb begin
      shifted   = (3*W)'($unsigned(req_chan.dividend)) << norm_shift_ff;
      fold_mask = {W{req_chan.dividend[sfdr_pkg::DIVIDEND_W-1]}};
      a_hi_in   = shifted[3*W-1:2*W] ^ (fold_mask & ~({W{1'b1}} << norm_shift_ff));
      a_mid_in  = shifted[2*W-1:W] ^ fold_mask;
      a_side_in.fold    = req_chan.dividend[sfdr_pkg::DIVIDEND_W-1];
      a_side_in.lo_limb = shifted[W-1:0] ^ fold_mask;
      a_side_in.q_hi    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (en) begin
         a_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         a_hi_ff   <= a_hi_in;
         a_mid_ff  <= a_mid_in;
         a_side_ff <= a_side_in;
      end
   end

   // Upper limb pair: gives the upper quotient word and a partial remainder.
   sfdr_step u_step_hi (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (a_valid_ff),
      .in_hi     (a_hi_ff),
      .in_lo     (a_mid_ff),
      .in_side   (a_side_ff),
      .divisor   (divisor_norm_ff),
      .recip     (reciprocal_ff),
      .out_valid (s1_valid),
      .out_quot  (s1_quot),
      .out_rem   (s1_rem),
      .out_side  (s1_side)
   );

   // Carry the upper quotient word alongside the second step.
   always_comb begin
      s2_side_in      = s1_side;
      s2_side_in.q_hi = s1_quot;
   end

   // Partial remainder with the low limb: lower quotient word and remainder.
   sfdr_step u_step_lo (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (s1_valid),
      .in_hi     (s1_rem),
      .in_lo     (s1_side.lo_limb),
      .in_side   (s2_side_in),
      .divisor   (divisor_norm_ff),
      .recip     (reciprocal_ff),
      .out_valid (s2_valid),
      .out_quot  (s2_quot),
      .out_rem   (s2_rem),
      .out_side  (s2_side)
   );

   // Unfold the quotient; for a folded item the remainder is d-1-r, then
   // shift it back down to the scale of the true divisor.
   always_comb begin
      o_quot_in = {s2_side.q_hi ^ {W{s2_side.fold}}, s2_quot ^ {W{s2_side.fold}}};
      rem_sum   = (s2_rem ^ {W{s2_side.fold}}) + (divisor_norm_ff & {W{s2_side.fold}});
      o_rem_in  = rem_sum >> norm_shift_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_valid_ff <= 1'b0;
      end else if (en) begin
         o_valid_ff <= s2_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         o_quot_ff <= o_quot_in;
         o_rem_ff  <= o_rem_in;
      end
   end

   assign rsp_chan.valid     = o_valid_ff;
   assign rsp_chan.quotient  = o_quot_ff;
   assign rsp_chan.remainder = o_rem_ff;

   `SFDR_ASSERT_NEXT(a_req_enters_fold, clock, reset,
      req_chan.valid && req_chan.ready, a_valid_ff)
   `SFDR_ASSERT_SAME(a_rsp_from_step, clock, reset, $rose(o_valid_ff), $past(s2_valid))

endmodule

/* tb/sfdr_checker.sv */
// Scoreboard for the signed floor divider: predicts each result and checks the response stream.
module sfdr_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [sfdr_pkg::DIVIDEND_W-1:0] req_dividend,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic [sfdr_pkg::DIVIDEND_W-1:0] rsp_quotient,
   input  logic [sfdr_pkg::LIMB_W-1:0]     rsp_remainder,
   input  logic                           csr_we,
   input  logic [sfdr_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [sfdr_pkg::LIMB_W-1:0]     csr_wdata,
   output int                             fail_count,
   output int                             pending
);

   typedef struct packed {
      logic [sfdr_pkg::DIVIDEND_W-1:0] dividend;
      logic [sfdr_pkg::DIVIDEND_W-1:0] quotient;
      logic [sfdr_pkg::LIMB_W-1:0]     remainder;
   } division_type;

   division_type owed_divisions[$];
   logic [sfdr_pkg::LIMB_W-1:0]  divisor_norm_reg;
   logic [sfdr_pkg::LIMB_W-1:0]  reciprocal_reg;
   logic [sfdr_pkg::SHIFT_W-1:0] norm_shift_reg;
   int                           failures = 0;

   // One reciprocal step on the limb pair {hi, lo}; returns {quotient, remainder}.
   function automatic logic [63:0] reciprocal_step(input logic [31:0] hi, input logic [31:0] lo,
                                                   input logic [31:0] d, input logic [31:0] v);
      logic [63:0] acc;
      logic [63:0] prod;
      logic [31:0] q_est;
      logic [31:0] q_frac;
      logic [31:0] rem;
      acc    = {32'd0, hi} * {32'd0, v} + {32'd0, lo};
      q_frac = acc[31:0];
      q_est  = acc[63:32] + hi + 32'd1;
      prod   = {32'd0, q_est} * {32'd0, d};
      rem    = lo - prod[31:0];
      if (rem > q_frac) begin
         q_est = q_est - 32'd1;
         rem   = rem + d;
      end
      if (rem >= d) begin
         q_est = q_est + 32'd1;
         rem   = rem - d;
      end
      return {q_est, rem};
   endfunction

   function automatic division_type floor_divide(input logic [63:0] dividend,
                                                 input logic [31:0] d, input logic [31:0] v,
                                                 input logic [4:0] shift);
      division_type res;
      logic [31:0]  fold;
      logic [31:0]  lo_limb;
      logic [31:0]  mid_limb;
      logic [31:0]  hi_limb;
      logic [63:0]  upper;
      logic [63:0]  lower;
      logic [31:0]  unshifted;
      int unsigned  s;
      s        = 32'(shift);
      // negative dividends are folded by one's complement
      fold     = {32{dividend[63]}};
      lo_limb  = fold ^ 32'(dividend << s);
      mid_limb = fold ^ 32'(dividend >> (32 - s));
      if (s != 0)
         hi_limb = (fold >> (32 - s)) ^ 32'(dividend >> (64 - s));
      else
         hi_limb = '0;
      upper         = reciprocal_step(hi_limb, mid_limb, d, v);
      lower         = reciprocal_step(upper[31:0], lo_limb, d, v);
      res.dividend  = dividend;
      res.quotient  = {fold ^ upper[63:32], fold ^ lower[63:32]};
      unshifted     = (fold ^ lower[31:0]) + (fold & d);
      res.remainder = unshifted >> s;
      return res;
   endfunction

   always @(posedge clock) begin : watch
      division_type due;
      if (reset) begin
         divisor_norm_reg = sfdr_pkg::RESET_DIVISOR_NORM;
         reciprocal_reg   = sfdr_pkg::RESET_RECIPROCAL;
         norm_shift_reg   = sfdr_pkg::RESET_NORM_SHIFT;
         owed_divisions.delete();
      end else begin
         // retire before predicting, so a response in the same cycle as its request cannot match
         if (rsp_valid && rsp_ready) begin
            if (owed_divisions.size() == 0) begin
               failures = failures + 1;
               $display("%0t: unexpected response, expected none, got quotient %0d remainder %0d",
                        $time, $signed(rsp_quotient), rsp_remainder);
            end else begin
               due = owed_divisions.pop_front();
               if (rsp_quotient !== due.quotient) begin
                  failures = failures + 1;
                  $display("%0t: quotient of %0d, expected %0d, got %0d", $time,
                           $signed(due.dividend), $signed(due.quotient), $signed(rsp_quotient));
               end
               if (rsp_remainder !== due.remainder) begin
                  failures = failures + 1;
                  $display("%0t: remainder of %0d, expected %0d, got %0d", $time,
                           $signed(due.dividend), due.remainder, rsp_remainder);
               end
            end
         end
         if (req_valid && req_ready)
            owed_divisions.push_back(floor_divide(req_dividend, divisor_norm_reg,
                                                  reciprocal_reg, norm_shift_reg));
         if (csr_we) begin
            case (csr_index)
               sfdr_pkg::CSR_DIVISOR_NORM: divisor_norm_reg = csr_wdata;
               sfdr_pkg::CSR_RECIPROCAL:   reciprocal_reg   = csr_wdata;
               sfdr_pkg::CSR_NORM_SHIFT:   norm_shift_reg   = csr_wdata[sfdr_pkg::SHIFT_W-1:0];
               default: ;  // unmapped index: drop
            endcase
         end
      end
      fail_count <= failures;
      pending    <= owed_divisions.size();
   end

endmodule

/* tb/tb_signed_floor_div_by_reciprocal_top.sv */
// Testbench top for the signed floor divider: stimulus, register setup and verdict.
module tb_signed_floor_div_by_reciprocal_top;

   // The unused fourth register slot; writes there must be ignored.
   localparam logic [sfdr_pkg::CSR_IDX_W-1:0] CSR_SPARE_INDEX = 2'd3;
   localparam int SETTING_COUNT     = 9;
   localparam int ITEMS_PER_SETTING = 156;
   // Cycles the tail waits after the final drain for stray responses.
   localparam int TAIL_CYCLES       = 20;
   // Cycles without any transfer before the run is declared hung.
   localparam int STALL_LIMIT       = 2000;

   logic                           clock = 1'b0;
   logic                           reset;
   logic                           csr_we;
   logic [sfdr_pkg::CSR_IDX_W-1:0] csr_index;
   logic [sfdr_pkg::LIMB_W-1:0]    csr_wdata;

   int          fail_count;
   int          pending;
   int          stall_cycles = 0;
   int          send_idle_pct = 29;
   int          recv_idle_pct = 79;
   logic [31:0] cur_divisor = 32'd86400;

   // Corner dividends, run against the reset divisor of 86400.
   logic [63:0] corner_values [16] = '{
      64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFF,
      64'h0000_0000_0001_517F, 64'h0000_0000_0001_5180, 64'hFFFF_FFFF_FFFE_AE80,
      64'hFFFF_FFFF_FFFE_AE7F, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000,
      64'h8000_0000_0000_0001, 64'h0000_0000_FFFF_FFFF, 64'h0000_0001_0000_0000,
      64'hFFFF_FFFF_0000_0000, 64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA,
      64'h0000_7FFF_FFFF_FFFF
   };

   sfdr_req_if req_chan ();
   sfdr_rsp_if rsp_chan ();

   signed_floor_div_by_reciprocal_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_chan  (req_chan),
      .rsp_chan  (rsp_chan),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   sfdr_checker checker_i (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_chan.valid),
      .req_ready     (req_chan.ready),
      .req_dividend  (req_chan.dividend),
      .rsp_valid     (rsp_chan.valid),
      .rsp_ready     (rsp_chan.ready),
      .rsp_quotient  (rsp_chan.quotient),
      .rsp_remainder (rsp_chan.remainder),
      .csr_we        (csr_we),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .fail_count    (fail_count),
      .pending       (pending)
   );

   // 4-unit clock period.
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Response back-pressure: drop ready at random with the current idle rate.
   // A rate of zero keeps ready high every cycle.
   always @(posedge clock) begin
      if (reset)
         rsp_chan.ready <= 1'b0;
      else
         rsp_chan.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Watchdog: count cycles with no transfer on either channel. Register
   // writes are far shorter than the limit, so it never trips on them.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready)) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= STALL_LIMIT) begin
            $display("signed_floor_div_by_reciprocal_top regression: fail");
            $finish;
         end
      end
   end

   // Offer one dividend and hold it until the transfer happens. Idle cycles
   // come first, so valid is only lowered in steps where it is not raised.
   task automatic push(input logic [63:0] value);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.dividend <= value;
      @(posedge clock);
      while (!req_chan.ready)
         @(posedge clock);
   endtask

   // Stop sending and wait until every predicted result has come back.
   // The extra edge lets the checker count the last transfer first.
   task automatic drain();
      req_chan.valid <= 1'b0;
      @(posedge clock);
      while (pending != 0)
         @(posedge clock);
   endtask

   // One register write per edge; write enable stays high across back-to-back
   // writes and the caller drops it afterward.
   task automatic write_csr(input logic [sfdr_pkg::CSR_IDX_W-1:0] idx,
                            input logic [sfdr_pkg::LIMB_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   // Program a consistent register set for a true divisor: normalize it,
   // derive the reciprocal, and put random junk above the 5 shift bits so
   // the write masking is exercised.
   task automatic set_divisor(input logic [31:0] divisor);
      logic [31:0] norm;
      logic [4:0]  shift;
      logic [63:0] inverse;
      norm  = (divisor == 32'd0) ? 32'd1 : divisor;
      shift = '0;
      while (!norm[31]) begin
         norm  = norm << 1;
         shift = shift + 5'd1;
      end
      // the quotient lies in [2^32, 2^33), so its low word is the reciprocal
      inverse     = 64'hFFFF_FFFF_FFFF_FFFF / {32'd0, norm};
      cur_divisor = (divisor == 32'd0) ? 32'd1 : divisor;
      write_csr(sfdr_pkg::CSR_DIVISOR_NORM, norm);
      write_csr(sfdr_pkg::CSR_RECIPROCAL, inverse[31:0]);
      write_csr(sfdr_pkg::CSR_NORM_SHIFT, {27'($urandom), shift});
   endtask

   // Register setting for each phase; the reset set is phase zero.
   task automatic configure(input int setting);
      logic [31:0] norm;
      logic [4:0]  shift;
      case (setting)
         1: set_divisor(32'd1);              // largest shift, reciprocal all ones
         2: begin
            set_divisor(32'hFFFF_FFFF);      // zero shift, top limb stays zero
            write_csr(CSR_SPARE_INDEX, $urandom);
         end
         3: set_divisor(32'h8000_0000);      // zero shift, smallest normalized divisor
         4: set_divisor(32'($urandom_range(2, 1000)));
         5: set_divisor($urandom);
         6: begin
            // inconsistent set: nothing is checked, the datapath just wraps
            norm  = $urandom;
            shift = 5'($urandom);
            cur_divisor = (norm >> shift) | 32'd1;
            write_csr(sfdr_pkg::CSR_DIVISOR_NORM, norm);
            write_csr(sfdr_pkg::CSR_RECIPROCAL, $urandom);
            write_csr(sfdr_pkg::CSR_NORM_SHIFT, {27'($urandom), shift});
         end
         7: set_divisor(32'd3);
         default: set_divisor($urandom >> $urandom_range(0, 31));
      endcase
      csr_we <= 1'b0;
   endtask

   // Random dividend shaped around the current divisor: full range, small
   // magnitudes, exact multiples and their neighbors, the signed extremes,
   // scattered magnitudes, and single-bit patterns or their complements.
   function automatic logic [63:0] pick_dividend(input logic [31:0] divisor);
      logic signed [63:0] wide;
      logic [63:0]        value;
      logic [63:0]        bit_mask;
      logic [31:0]        count;
      case ($urandom_range(0, 5))
         0: value = {$urandom, $urandom};
         1: value = 64'($urandom_range(0, 2097152)) - 64'd1048576;
         2: begin
            count = $urandom;
            value = {{32{count[31]}}, count} * {32'd0, divisor}
                  + 64'($urandom_range(0, 2)) - 64'd1;
         end
         3: begin
            if ($urandom_range(0, 1) != 0)
               value = 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 3));
            else
               value = 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3));
         end
         4: begin
            wide  = {$urandom, $urandom};
            value = wide >>> $urandom_range(0, 63);
         end
         default: begin
            bit_mask = 64'd1 << $urandom_range(0, 63);
            value    = ($urandom_range(0, 1) != 0) ? bit_mask : ~bit_mask;
         end
      endcase
      return value;
   endfunction

   initial begin
      // Known values on the driven inputs from time zero; ready comes up low
      // at the first edge under reset.
      reset             <= 1'b1;
      csr_we            <= 1'b0;
      csr_index         <= sfdr_pkg::CSR_DIVISOR_NORM;
      csr_wdata         <= '0;
      req_chan.valid    <= 1'b0;
      req_chan.dividend <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (int setting = 0; setting < SETTING_COUNT; setting++) begin
         // Idle pattern: sender light and receiver heavy, then the reverse,
         // then both streaming with no gaps.
         if (setting < 3) begin
            send_idle_pct = 29;
            recv_idle_pct = 79;
         end else if (setting < 6) begin
            send_idle_pct = 79;
            recv_idle_pct = 29;
         end else begin
            send_idle_pct = 0;
            recv_idle_pct = 0;
         end
         // Registers change only with the pipeline empty.
         if (setting != 0) begin
            drain();
            configure(setting);
         end else begin
            foreach (corner_values[i])
               push(corner_values[i]);
         end
         repeat (ITEMS_PER_SETTING)
            push(pick_dividend(cur_divisor));
      end

      drain();
      // Hold off a little longer to catch any response nobody asked for.
      repeat (TAIL_CYCLES) @(posedge clock);
      if (fail_count == 0)
         $display("signed_floor_div_by_reciprocal_top regression: pass");
      else
         $display("signed_floor_div_by_reciprocal_top regression: fail");
      $finish;
   end

endmodule

/* signed_floor_div_by_reciprocal_top.f */
+incdir+rtl/core
rtl/core/sfdr_pkg.sv
rtl/core/sfdr_req_if.sv
rtl/core/sfdr_rsp_if.sv
rtl/core/sfdr_step.sv
rtl/core/signed_floor_div_by_reciprocal_top.sv
tb/sfdr_checker.sv
tb/tb_signed_floor_div_by_reciprocal_top.sv
